FILE: hw/rtl/smmt_pkg.sv
// Shared types and constants for the square matrix multiply/transpose core.
// Used by the controller, the datapath and the top level.
`default_nettype none

package smmt_pkg;

  localparam int MAX_N     = 8;
  localparam int IDX_W     = 3;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int MEM_DEPTH = MAX_N * MAX_N;
  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int ACC_W     = 35;
  localparam int SIZE_W    = 4;
  localparam int REQ_W     = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd3;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_N);

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_MUL    = 2'd2,
    REQ_TRN    = 2'd3
  } smmt_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN1,
    S_DRAIN2,
    S_EMIT
  } smmt_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              rd_en;
    logic              first;
    logic              trn;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic              emit;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } smmt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
  } smmt_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/smmt_ctrl.sv
// Controller state machine: size register, index counters and read sequencing.
// Depends on smmt_pkg; drives the datapath through smmt_cmd_t.
`default_nettype none

module smmt_ctrl
  import smmt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [SIZE_W-1:0] cfg_wdata,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [REQ_W-1:0]  in_req,
  input  wire smmt_sts_t         sts,
  output smmt_cmd_t              cmd
);

  smmt_state_t       state_r, state_nxt;
  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic              trn_r, trn_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [SIZE_W-1:0] n_act;
  logic [SIZE_W-1:0] n_m1;
  logic              accept;
  logic              i_end, j_end, k_end;
  smmt_req_t         req;

  assign req    = smmt_req_t'(in_req);
  assign accept = in_tvalid && in_tready;
  assign n_act  = (size_r > SIZE_MAX) ? SIZE_MAX : size_r;
  assign n_m1   = n_r - SIZE_W'(1);
  assign i_end  = ({1'b0, i_r} == n_m1);
  assign j_end  = ({1'b0, j_r} == n_m1);
  assign k_end  = ({1'b0, k_r} == n_m1);

  // Size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      size_r <= cfg_wdata;
    end
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      n_r     <= '0;
      trn_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      trn_r   <= trn_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Next state and counter updates
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    trn_nxt   = trn_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (req == REQ_MUL || req == REQ_TRN) && n_act != '0) begin
          state_nxt = S_ISSUE;
          n_nxt     = n_act;
          trn_nxt   = (req == REQ_TRN);
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      S_ISSUE: begin
        if (trn_r || k_end) begin
          state_nxt = S_DRAIN1;
          k_nxt     = '0;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_DRAIN1: state_nxt = S_DRAIN2;
      S_DRAIN2: state_nxt = S_EMIT;
      S_EMIT: begin
        if (sts.out_free) begin
          if (j_end) begin
            j_nxt = '0;
            if (i_end) begin
              state_nxt = S_IDLE;
            end else begin
              i_nxt     = i_r + IDX_W'(1);
              state_nxt = S_ISSUE;
            end
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = S_ISSUE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    in_tready     = (state_r == S_IDLE);
    cmd           = '0;
    cmd.wr_a      = accept && (req == REQ_LOAD_A);
    cmd.wr_b      = accept && (req == REQ_LOAD_B);
    cmd.trn       = trn_r;
    cmd.first     = (k_r == '0);
    cmd.rd_a_addr = trn_r ? {j_r, i_r} : {i_r, k_r};
    cmd.rd_b_addr = {k_r, j_r};
    cmd.row       = i_r;
    cmd.col       = j_r;
    cmd.last      = i_end && j_end;
    case (state_r)
      S_ISSUE: cmd.rd_en = 1'b1;
      S_EMIT:  cmd.emit  = sts.out_free;
      default: cmd.rd_en = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/smmt_dpath.sv
// Datapath: A and B element memories, one shared multiply-accumulate
// pipeline and the output word register. Depends on smmt_pkg.
`default_nettype none

module smmt_dpath
  import smmt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire smmt_cmd_t         cmd,
  output smmt_sts_t              sts,
  input  wire logic [IDX_W-1:0]  in_row,
  input  wire logic [IDX_W-1:0]  in_col,
  input  wire logic [ELEM_W-1:0] in_value,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [IDX_W-1:0]       out_row,
  output logic [IDX_W-1:0]       out_col,
  output logic [ACC_W-1:0]       out_value,
  output logic                   out_last
);

  logic [ELEM_W-1:0] mem_a [MEM_DEPTH];
  logic [ELEM_W-1:0] mem_b [MEM_DEPTH];

  logic [ELEM_W-1:0]        a_q_r, b_q_r;
  logic                     v1_r, f1_r, v2_r, f2_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic                     out_valid_r;
  logic [IDX_W-1:0]         out_row_r, out_col_r;
  logic [ACC_W-1:0]         out_value_r;
  logic                     out_last_r;

  // Write loaded elements, read operands with registered data
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[{in_row, in_col}] <= in_value;
    end
    if (cmd.wr_b) begin
      mem_b[{in_row, in_col}] <= in_value;
    end
    a_q_r <= mem_a[cmd.rd_a_addr];
    b_q_r <= mem_b[cmd.rd_b_addr];
  end

  // Multiply, or pass the A element through for a transpose
  always_comb begin
    if (cmd.trn) begin
      prod_nxt = PROD_W'($signed(a_q_r));
    end else begin
      prod_nxt = $signed(a_q_r) * $signed(b_q_r);
    end
  end

  assign prod_ext = ACC_W'(prod_r);

  // Pipeline valid and first-term flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      f1_r <= 1'b0;
      f2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      f1_r <= cmd.first;
      v2_r <= v1_r;
      f2_r <= f1_r;
    end
  end

  // Product register and accumulator
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (v2_r) begin
      acc_r <= f2_r ? prod_ext : acc_r + prod_ext;
    end
  end

  // Output word register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= cmd.row;
      out_col_r   <= cmd.col;
      out_value_r <= acc_r;
      out_last_r  <= cmd.last;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_row      = out_row_r;
  assign out_col      = out_col_r;
  assign out_value    = out_value_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/square_matrix_multiply_transpose_core.sv
// Top level of the square matrix multiply/transpose core.
// Depends on smmt_pkg, smmt_ctrl and smmt_dpath.
//
// The core holds two 8x8 matrices of signed 16-bit elements and works on an
// n x n corner of them, n set by cfg_wdata (saturated at 8, reset 3). A load
// word writes one element and produces nothing. A multiply word emits the
// n*n entries of A*B row by row as exact 35-bit sums; each entry is summed
// from n terms through the single shared multiply-accumulate unit fed by one
// read port on each element memory. A transpose word emits A transposed.
// tlast marks the final entry of a run. A new word is taken only once the
// previous run has been handed to the output register; an element must be
// loaded before it is read. Change the size only while the core is idle.
`default_nettype none

module square_matrix_multiply_transpose_core
  import smmt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [SIZE_W-1:0]     cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // in_tdata: row[2:0], col[5:3], value[21:6], zero pad[23:22]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: req_type[1:0]
  input  wire logic [REQ_W-1:0]      in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // out_tdata: out_row[2:0], out_col[5:3], out_value[40:6], zero pad[47:41]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tlast
);

  smmt_cmd_t        cmd;
  smmt_sts_t        sts;
  logic [IDX_W-1:0] o_row, o_col;
  logic [ACC_W-1:0] o_value;

  smmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_req    (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  smmt_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_row     (in_tdata[2:0]),
    .in_col     (in_tdata[5:3]),
    .in_value   (in_tdata[21:6]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_row    (o_row),
    .out_col    (o_col),
    .out_value  (o_value),
    .out_last   (out_tlast)
  );

  // Pack the result word
  assign out_tdata = {7'd0, o_value, o_col, o_row};

endmodule

`default_nettype wire

FILE: hw/rtl/smmt_checker.sv
// Port-level checks for the matrix multiply/transpose core, and the bind
// that attaches them to the top level. Depends on smmt_pkg.
`default_nettype none

module smmt_checker
  import smmt_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tlast
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid right after reset");

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  // The last entry of a run sits on the diagonal
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[2:0] == out_tdata[5:3])
    else $error("last entry off the diagonal");

  // Within a run entries come in row-major order: a non-last entry is
  // followed by one in the same row or the next row
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 out_tvalid |->
      (out_tdata[2:0] == $past(out_tdata[2:0]) &&
       out_tdata[5:3] == $past(out_tdata[5:3]) + 3'd1) ||
      (out_tdata[2:0] == $past(out_tdata[2:0]) + 3'd1 && out_tdata[5:3] == 3'd0))
    else $error("result entries out of row-major order");

endmodule

bind square_matrix_multiply_transpose_core smmt_checker u_smmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
